[rtl/ring_fir_filter_95_taps_top_macros.svh]
// Assertion macros for the ring FIR filter RTL.
// Included by modules that carry concurrent assertions; expects clk_i and rst_ni in scope.
`ifndef RING_FIR_FILTER_95_TAPS_TOP_MACROS_SVH
`define RING_FIR_FILTER_95_TAPS_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// plain property checked on every clock edge outside reset
`define RFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// same-cycle implication
`define RFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RFF_ASSERT(lbl, prop, msg)
`define RFF_ASSERT_IMP(lbl, ante, cons, msg)
`define RFF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/rff_pkg.sv]
// Shared types and constants for the ring FIR filter.
// No dependencies; imported by rff_mac, ring_fir_filter_95_taps_top and the testbench.
package rff_pkg;

  localparam int MAX_TAPS   = 95;
  localparam int MIN_TAPS   = 2;
  localparam int HIST_DEPTH = MAX_TAPS - 1;
  localparam int TAP_W      = 7;
  localparam int SAMPLE_W   = 16;
  localparam int COEFF_W    = 16;
  localparam int ACC_W      = 32;
  localparam int PROD_W     = SAMPLE_W + COEFF_W;
  localparam int COEFF_AW   = $clog2(MAX_TAPS);
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  typedef enum logic [1:0] {
    OP_FILTER  = 2'd0,
    OP_LOAD    = 2'd1,
    OP_RESTART = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_e;

  // control into the multiply-accumulate unit
  typedef struct packed {
    logic start;
    logic valid;
    logic last;
  } mac_ctrl_t;

endpackage

[rtl/rff_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the coefficient store and the history ring.
module rff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 95
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rff_mac.sv]
// Shared multiply-accumulate unit: one product per cycle, negated scaled accumulation.
// Depends on rff_pkg.
module rff_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  rff_pkg::mac_ctrl_t                     ctrl_i,
  input  logic signed [rff_pkg::COEFF_W-1:0]     coeff_i,
  input  logic signed [rff_pkg::SAMPLE_W-1:0]    samp_i,
  output logic [rff_pkg::ACC_W-1:0]              acc_o,
  output logic                                   done_o
);
  import rff_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     p_valid_q;
  logic                     p_last_q;
  logic [ACC_W-1:0]         acc_q;
  logic                     done_q;
  logic [ACC_W-1:0]         scaled;

  // product scaled by four, wrapping to the accumulator width
  assign scaled = ACC_W'({prod_q[PROD_W-3:0], 2'b00});

  // product register, no reset on payload
  always_ff @(posedge clk_i) begin
    prod_q <= coeff_i * samp_i;
  end

  // product valid tracking and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_last_q  <= 1'b0;
      acc_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      p_valid_q <= ctrl_i.valid;
      p_last_q  <= ctrl_i.valid & ctrl_i.last;
      done_q    <= p_valid_q & p_last_q;
      if (ctrl_i.start) begin
        acc_q <= '0;
      end else if (p_valid_q) begin
        acc_q <= acc_q - scaled;
      end
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

[rtl/ring_fir_filter_95_taps_top.sv]
// Top level of the ring FIR filter: sequencer, coefficient and history stores, result register.
// Depends on rff_pkg, rff_ram, rff_mac and ring_fir_filter_95_taps_top_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: operation_i selects
//   filter sample, load coefficient, restart ring position or clear history.
//   Output channel (out_valid_o / out_stall_i) returns filtered_o, one per filter request.
//   Config channel (cfg_valid_i / cfg_ready_o) writes the tap count; write it only while idle.
// Timing:
//   Load, restart and clear requests give no result and leave the block idle.
//   A filter request walks all taps through one shared multiplier, one tap per cycle:
//   the result register loads at the end of the walk (taps clamped to 2..95) and the
//   next request is taken once the block is back in idle, so a new filter request is
//   not taken while one is still being worked.
//   in_stall_o stays high for the whole walk.
// Reset:
//   Coefficients and history read as zero, ring position zero, tap count 95.
//   Per-entry valid bits make both stores read zero until written, so no clear pass.
// Backpressure:
//   A finished result waits in the output register while out_stall_i is high; a second
//   filter request may run meanwhile and holds at its end until the register frees.
module ring_fir_filter_95_taps_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input requests
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            operation_i,
  input  logic signed [rff_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic [rff_pkg::TAP_W-1:0]             coeff_index_i,
  input  logic signed [rff_pkg::COEFF_W-1:0]    coeff_value_i,
  // results
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rff_pkg::ACC_W-1:0]      filtered_o,
  // tap count register
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rff_pkg::TAP_W-1:0]             cfg_num_taps_i
);
  import rff_pkg::*;

  state_e               state_q, state_d;
  logic [TAP_W-1:0]     tap_cfg_q;
  logic [TAP_W-1:0]     taps_eff;
  logic [TAP_W-1:0]     hist_len;
  logic [TAP_W-1:0]     hist_len_q, hist_len_d;
  logic [HIST_AW-1:0]   ring_pos_q, ring_pos_d;
  logic [HIST_AW-1:0]   start_q, start_d;
  logic [HIST_AW-1:0]   pos_q, pos_d;
  logic [COEFF_AW-1:0]  k_q, k_d;
  logic                 issuing_q, issuing_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic [MAX_TAPS-1:0]  coeff_vld_q, coeff_vld_d;
  logic [HIST_DEPTH-1:0] hist_vld_q, hist_vld_d;
  logic                 out_valid_q, out_valid_d;
  logic [ACC_W-1:0]     filtered_q, filtered_d;
  logic                 s1_valid_q, s1_last_q;
  logic                 coeff_ok_q, hist_ok_q;
  logic                 accept;
  logic                 last_issue;
  logic [HIST_AW:0]     pos_inc;
  logic [HIST_AW:0]     start_inc;
  logic                 coeff_we;
  logic                 hist_we;
  logic [COEFF_W-1:0]   coeff_rd;
  logic [SAMPLE_W-1:0]  hist_rd;
  logic signed [COEFF_W-1:0]  mac_coeff;
  logic signed [SAMPLE_W-1:0] mac_samp;
  mac_ctrl_t            mac_ctrl;
  logic [ACC_W-1:0]     mac_acc;
  logic                 mac_done;

  // effective tap count and history length
  always_comb begin
    if (tap_cfg_q < TAP_W'(MIN_TAPS)) begin
      taps_eff = TAP_W'(MIN_TAPS);
    end else if (tap_cfg_q > TAP_W'(MAX_TAPS)) begin
      taps_eff = TAP_W'(MAX_TAPS);
    end else begin
      taps_eff = tap_cfg_q;
    end
  end
  assign hist_len = taps_eff - TAP_W'(1);

  assign accept      = in_valid_i & ~in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign last_issue  = issuing_q & (k_q == COEFF_AW'(hist_len_q));
  assign pos_inc     = {1'b0, pos_q} + (HIST_AW+1)'(1);
  assign start_inc   = {1'b0, start_q} + (HIST_AW+1)'(1);
  assign coeff_we    = accept & (op_e'(operation_i) == OP_LOAD) &
                       (coeff_index_i < TAP_W'(MAX_TAPS));

  // tap count register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_cfg_q <= TAP_W'(MAX_TAPS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      tap_cfg_q <= cfg_num_taps_i;
    end
  end

  // sequencer next state and datapath control
  always_comb begin
    state_d     = state_q;
    hist_len_d  = hist_len_q;
    ring_pos_d  = ring_pos_q;
    start_d     = start_q;
    pos_d       = pos_q;
    k_d         = k_q;
    issuing_d   = issuing_q;
    sample_d    = sample_q;
    coeff_vld_d = coeff_vld_q;
    hist_vld_d  = hist_vld_q;
    out_valid_d = out_valid_q & out_stall_i;
    filtered_d  = filtered_q;
    hist_we     = 1'b0;
    mac_ctrl    = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_FILTER: begin
              sample_d   = sample_i;
              hist_len_d = hist_len;
              if (TAP_W'(ring_pos_q) >= hist_len) begin
                start_d = '0;
                pos_d   = '0;
              end else begin
                start_d = ring_pos_q;
                pos_d   = ring_pos_q;
              end
              k_d            = '0;
              issuing_d      = 1'b1;
              mac_ctrl.start = 1'b1;
              state_d        = ST_CALC;
            end
            OP_LOAD: begin
              if (coeff_we) begin
                coeff_vld_d[coeff_index_i] = 1'b1;
              end
            end
            OP_RESTART: begin
              ring_pos_d = '0;
            end
            OP_CLEAR: begin
              ring_pos_d = '0;
              hist_vld_d = '0;
            end
            default: begin
              ring_pos_d = ring_pos_q;
            end
          endcase
        end
      end
      ST_CALC: begin
        // one tap per cycle: coefficient k against ring entry pos
        if (issuing_q) begin
          k_d = k_q + COEFF_AW'(1);
          if (TAP_W'(pos_inc) >= hist_len_q) begin
            pos_d = '0;
          end else begin
            pos_d = HIST_AW'(pos_inc);
          end
          if (last_issue) begin
            issuing_d = 1'b0;
          end
        end
        mac_ctrl.valid = s1_valid_q;
        mac_ctrl.last  = s1_last_q;
        if (mac_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // deliver once the result register is free, storing the sample at the same time
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          filtered_d  = mac_acc;
          hist_we     = 1'b1;
          hist_vld_d[start_q] = 1'b1;
          if (TAP_W'(start_inc) >= hist_len_q) begin
            ring_pos_d = '0;
          end else begin
            ring_pos_d = HIST_AW'(start_inc);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ring_pos_q  <= '0;
      issuing_q   <= 1'b0;
      coeff_vld_q <= '0;
      hist_vld_q  <= '0;
      out_valid_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      hist_len_q  <= '0;
      start_q     <= '0;
      pos_q       <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      ring_pos_q  <= ring_pos_d;
      issuing_q   <= issuing_d;
      coeff_vld_q <= coeff_vld_d;
      hist_vld_q  <= hist_vld_d;
      out_valid_q <= out_valid_d;
      s1_valid_q  <= issuing_q;
      s1_last_q   <= last_issue;
      hist_len_q  <= hist_len_d;
      start_q     <= start_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
    end
  end

  // payload registers: sample, read-valid flags, result
  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    filtered_q <= filtered_d;
    coeff_ok_q <= coeff_vld_q[k_q];
    hist_ok_q  <= hist_vld_q[pos_q];
  end

  // coefficient store
  rff_ram #(
    .WIDTH(COEFF_W),
    .DEPTH(MAX_TAPS)
  ) u_coeff_ram (
    .clk_i   (clk_i),
    .we_i    (coeff_we),
    .waddr_i (COEFF_AW'(coeff_index_i)),
    .wdata_i (coeff_value_i),
    .raddr_i (k_q),
    .rdata_o (coeff_rd)
  );

  // history ring
  rff_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (start_q),
    .wdata_i (sample_q),
    .raddr_i (pos_q),
    .rdata_o (hist_rd)
  );

  // operand select: unwritten entries read zero, last tap takes the new sample
  assign mac_coeff = coeff_ok_q ? coeff_rd : '0;
  assign mac_samp  = s1_last_q ? sample_q : (hist_ok_q ? hist_rd : '0);

  rff_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .coeff_i (mac_coeff),
    .samp_i  (mac_samp),
    .acc_o   (mac_acc),
    .done_o  (mac_done)
  );

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

  `include "ring_fir_filter_95_taps_top_macros.svh"

  `RFF_ASSERT_IMP(a_k_bound, issuing_q, k_q <= COEFF_AW'(hist_len_q), "tap index past history length")
  `RFF_ASSERT_IMP(a_pos_bound, issuing_q && !last_issue, TAP_W'(pos_q) < hist_len_q, "ring read past end")
  `RFF_ASSERT_IMP(a_done_calc, mac_done, (state_q == ST_CALC) && !issuing_q, "mac done while issuing")
  `RFF_ASSERT_NEXT(a_result_load, (state_q == ST_DONE) && (state_d == ST_IDLE), out_valid_o, "result not presented")
  `RFF_ASSERT_IMP(a_hist_len, state_q != ST_IDLE, (hist_len_q >= TAP_W'(1)) && (hist_len_q <= TAP_W'(HIST_DEPTH)), "bad history length")

endmodule

[bench/ring_fir_filter_95_taps_top_tb.sv]
// Self-checking testbench for the ring FIR filter top level.
// Depends on rff_pkg and ring_fir_filter_95_taps_top; a directed table and random requests are
// checked against an internal predictor of the tap sum, coefficient store and history ring.
module ring_fir_filter_95_taps_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rff_pkg::*;

  localparam int DRAIN_CYCLES  = 110;   // longest filter walk plus margin
  localparam int STALL_LIMIT   = 20000; // cycles without any handshake
  localparam int SEGMENTS      = 12;
  localparam int SEGMENT_ITEMS = 84;

  // directed stimulus row; known marks a result typed in by hand
  typedef struct packed {
    op_e         op;
    logic [15:0] smp;
    logic [6:0]  idx;
    logic [15:0] val;
    logic        known;
    logic [31:0] result;
  } stim_row_t;

  localparam int N_DIRECTED = 20;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_FILTER,  16'h7FFF, 7'd0,   16'h0000, 1'b1, 32'h0000_0000}, // all coefficients zero
    '{OP_LOAD,    16'h0000, 7'd94,  16'h8000, 1'b0, 32'h0},
    '{OP_FILTER,  16'h8000, 7'd0,   16'h0000, 1'b1, 32'h0000_0000}, // product 2^30 wraps away
    '{OP_FILTER,  16'h7FFF, 7'd0,   16'h0000, 1'b1, 32'hFFFE_0000},
    '{OP_LOAD,    16'hFFFF, 7'd0,   16'h7FFF, 1'b0, 32'h0},
    '{OP_LOAD,    16'h0000, 7'd127, 16'h3039, 1'b0, 32'h0},          // index out of range
    '{OP_LOAD,    16'h0000, 7'd95,  16'hFFFF, 1'b0, 32'h0},          // index out of range
    '{OP_FILTER,  16'h0001, 7'd127, 16'hFFFF, 1'b0, 32'h0},
    '{OP_FILTER,  16'hFFFF, 7'd0,   16'h0000, 1'b0, 32'h0},
    '{OP_RESTART, 16'hFFFF, 7'd127, 16'hFFFF, 1'b0, 32'h0},
    '{OP_FILTER,  16'h8000, 7'd0,   16'h0000, 1'b0, 32'h0},
    '{OP_LOAD,    16'h0000, 7'd45,  16'h5555, 1'b0, 32'h0},
    '{OP_LOAD,    16'h0000, 7'd44,  16'hAAAA, 1'b0, 32'h0},
    '{OP_FILTER,  16'h7FFF, 7'd0,   16'h0000, 1'b0, 32'h0},
    '{OP_CLEAR,   16'hFFFF, 7'd127, 16'hFFFF, 1'b0, 32'h0},
    '{OP_FILTER,  16'h0000, 7'd0,   16'h0000, 1'b1, 32'h0000_0000}, // cleared history, zero input
    '{OP_FILTER,  16'h1234, 7'd0,   16'h0000, 1'b0, 32'h0},
    '{OP_RESTART, 16'h0000, 7'd0,   16'h0000, 1'b0, 32'h0},
    '{OP_FILTER,  16'h8000, 7'd0,   16'h0000, 1'b0, 32'h0},
    '{OP_FILTER,  16'h7FFF, 7'd0,   16'h0000, 1'b0, 32'h0}
  };

  // tap counts per random segment, extremes and out-of-range values included
  localparam logic [6:0] TAP_PLAN [SEGMENTS] = '{
    7'd2, 7'd0, 7'd127, 7'd5, 7'd1, 7'd96, 7'd95, 7'd3, 7'd45, 7'd44, 7'd16, 7'd7
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = OP_FILTER;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic [TAP_W-1:0]           coeff_index_i = '0;
  logic signed [COEFF_W-1:0]  coeff_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic signed [ACC_W-1:0]    filtered_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [TAP_W-1:0]           cfg_num_taps_i = '0;

  // predictor state
  logic signed [COEFF_W-1:0]  coeff_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
  int                         oldest_pos;
  logic [TAP_W-1:0]           taps_reg;

  logic [ACC_W-1:0] pending_filtered [$];
  int               error_count = 0;
  int               quiet_cycles = 0;
  int               send_gap_pct = 0;
  int               recv_stall_pct = 0;

  ring_fir_filter_95_taps_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .sample_i        (sample_i),
    .coeff_index_i   (coeff_index_i),
    .coeff_value_i   (coeff_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .filtered_o      (filtered_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_num_taps_i  (cfg_num_taps_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // negated tap sum for one sample, then write it over the oldest entry
  function automatic logic [ACC_W-1:0] filter_sample(input logic signed [SAMPLE_W-1:0] s);
    int                     taps;
    int                     hlen;
    int                     pos;
    logic [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0] prod;
    taps = taps_reg;
    if (taps < MIN_TAPS) taps = MIN_TAPS;
    if (taps > MAX_TAPS) taps = MAX_TAPS;
    hlen = taps - 1;
    // stale ring position after a tap count change
    if (oldest_pos >= hlen) oldest_pos = 0;
    pos = oldest_pos;
    acc = '0;
    for (int k = 0; k < hlen; k++) begin
      prod = coeff_mem[k] * hist_mem[pos];
      acc = acc - (prod << 2);
      pos++;
      if (pos >= hlen) pos = 0;
    end
    prod = coeff_mem[hlen] * s;
    acc = acc - (prod << 2);
    hist_mem[oldest_pos] = s;
    oldest_pos++;
    if (oldest_pos >= hlen) oldest_pos = 0;
    return acc;
  endfunction

  // predictor update for one accepted request
  function automatic void apply_request(input op_e op, input logic signed [15:0] s,
                                        input logic [6:0] idx, input logic signed [15:0] val,
                                        input logic known, input logic [31:0] typed);
    logic [ACC_W-1:0] res;
    case (op)
      OP_LOAD: begin
        if (idx < MAX_TAPS) coeff_mem[idx] = val;
      end
      OP_RESTART: begin
        oldest_pos = 0;
      end
      OP_CLEAR: begin
        foreach (hist_mem[i]) hist_mem[i] = '0;
        oldest_pos = 0;
      end
      default: begin
        res = filter_sample(s);
        pending_filtered.push_back(known ? typed : res);
      end
    endcase
  endfunction

  // one input request; returns at the edge that accepts it
  task automatic send_request(input op_e op, input logic [15:0] s, input logic [6:0] idx,
                              input logic [15:0] val, input logic known,
                              input logic [31:0] typed);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    sample_i      <= s;
    coeff_index_i <= idx;
    coeff_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    apply_request(op, s, idx, val, known, typed);
  endtask

  // random request: mostly filters over loaded coefficients
  task automatic send_random_request();
    int          pick;
    op_e         op;
    logic [15:0] s;
    logic [6:0]  idx;
    pick = $urandom_range(99);
    if (pick < 62) op = OP_FILTER;
    else if (pick < 92) op = OP_LOAD;
    else if (pick < 96) op = OP_RESTART;
    else op = OP_CLEAR;
    case ($urandom_range(7))
      0: s = 16'h8000;
      1: s = 16'h7FFF;
      default: s = 16'($urandom);
    endcase
    idx = ($urandom_range(9) == 0) ? 7'($urandom_range(127, MAX_TAPS))
                                   : 7'($urandom_range(MAX_TAPS - 1));
    send_request(op, s, idx, 16'($urandom), 1'b0, '0);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_filtered.size() != 0) @(negedge clk_i);
  endtask

  // tap count write, only with the block idle
  task automatic write_num_taps(input logic [6:0] taps);
    release_input();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_num_taps_i <= taps;
    do @(posedge clk_i); while (!cfg_ready_o);
    taps_reg = taps;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_gap_pct   = 6;
        recv_stall_pct = 86;
      end
      1: begin
        send_gap_pct   = 86;
        recv_stall_pct = 6;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // result check against the oldest pending filter request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_filtered.size() == 0) begin
        $error("filtered: no request pending, got %0d", filtered_o);
        error_count++;
      end else begin
        if (filtered_o !== pending_filtered[0]) begin
          $error("filtered: expected %0d, got %0d", $signed(pending_filtered[0]), filtered_o);
          error_count++;
        end
        void'(pending_filtered.pop_front());
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    foreach (coeff_mem[i]) coeff_mem[i] = '0;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    oldest_pos = 0;
    taps_reg   = 7'd95;
    set_idling(0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table at the reset tap count
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_request(DIRECTED[r].op, DIRECTED[r].smp, DIRECTED[r].idx, DIRECTED[r].val,
                   DIRECTED[r].known, DIRECTED[r].result);
    end

    // random segments, one tap count each
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_idling(seg / 4);
      write_num_taps(TAP_PLAN[seg]);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if (n == SEGMENT_ITEMS / 2) begin
          // hold off until every result is back
          release_input();
          wait_drained();
        end
        send_random_request();
      end
    end

    release_input();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/rff_pkg.sv
rtl/rff_ram.sv
rtl/rff_mac.sv
rtl/ring_fir_filter_95_taps_top.sv
bench/ring_fir_filter_95_taps_top_tb.sv
